// ===== hdl/layer_blend_mode_pixel_defines.svh =====
// Assertion macros shared by the layer blend checker.
`ifndef LAYER_BLEND_MODE_PIXEL_DEFINES_SVH
`define LAYER_BLEND_MODE_PIXEL_DEFINES_SVH

// property checked on every rising edge, off while reset is low
`define LBM_ASSERT_RST(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// property checked on every rising edge, reset included
`define LBM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hdl/lbm_pkg.sv =====
// Types, mode codes and constant tables for the layer blend pipeline.
package lbm_pkg;

	localparam int LBM_STAGES = 23;
	localparam int DIV_STEPS = 17;

	localparam logic [4:0] M_NORMAL = 5'd0;
	localparam logic [4:0] M_DISSOLVE = 5'd1;
	localparam logic [4:0] M_DARKEN = 5'd2;
	localparam logic [4:0] M_MULTIPLY = 5'd3;
	localparam logic [4:0] M_COLOR_BURN = 5'd4;
	localparam logic [4:0] M_LINEAR_BURN = 5'd5;
	localparam logic [4:0] M_LIGHTEN = 5'd6;
	localparam logic [4:0] M_SCREEN = 5'd7;
	localparam logic [4:0] M_COLOR_DODGE = 5'd8;
	localparam logic [4:0] M_LINEAR_DODGE = 5'd9;
	localparam logic [4:0] M_OVERLAY = 5'd10;
	localparam logic [4:0] M_SOFT_LIGHT = 5'd11;
	localparam logic [4:0] M_HARD_LIGHT = 5'd12;
	localparam logic [4:0] M_VIVID_LIGHT = 5'd13;
	localparam logic [4:0] M_LINEAR_LIGHT = 5'd14;
	localparam logic [4:0] M_PIN_LIGHT = 5'd15;
	localparam logic [4:0] M_HARD_MIX = 5'd16;
	localparam logic [4:0] M_DIFFERENCE = 5'd17;
	localparam logic [4:0] M_EXCLUSION = 5'd18;
	localparam logic [4:0] M_SUBTRACT = 5'd19;
	localparam logic [4:0] M_DIVIDE = 5'd20;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_OPACITY = 1'b1;

	localparam logic [16:0] ONE_Q = 17'd65536;
	localparam logic [7:0] HALF_BYTE = 8'd127;
	localparam logic [7:0] OPAQUE = 8'd255;
	localparam logic [15:0] RECIP_255 = 16'd32897;
	localparam int RECIP_SHIFT = 23;

	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] opacity;
	} lbm_cfg_t;

	typedef struct packed {
		logic [7:0]  u;
		logic [7:0]  d;
		logic        pick;
		logic [17:0] mx;
		logic [16:0] my;
		logic        neg;
		logic [16:0] num;
		logic [16:0] dvs;
		logic        ov;
	} op_t;

	typedef struct packed {
		logic [7:0]  u;
		logic [7:0]  d;
		logic        pick;
		logic [34:0] prod;
		logic        neg;
		logic [32:0] rem;
		logic [16:0] dvs;
		logic [16:0] quo;
		logic        ov;
	} dv_t;

	typedef logic [16:0] qtab_t [0:255];

	function automatic longint unsigned to_q(input longint unsigned x);
		return (x * 65536 + 127) / 255;
	endfunction

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned x;
		longint unsigned res;
		longint unsigned probe;
		x = v;
		res = 0;
		probe = 64'd1 << 40;
		while (probe > x)
			probe = probe >> 2;
		while (probe != 0) begin
			if (x >= res + probe) begin
				x = x - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic qtab_t build_toq();
		qtab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = 17'(to_q(longint'(i)));
		return t;
	endfunction

	// b - b*b, soft light for dark upper channel
	function automatic qtab_t build_sl_lo();
		qtab_t t;
		longint unsigned b;
		for (int i = 0; i < 256; i++) begin
			b = to_q(longint'(i));
			t[i] = 17'(b - ((b * b + 32768) >> 16));
		end
		return t;
	endfunction

	// sqrt(b) - b, soft light for light upper channel
	function automatic qtab_t build_sl_hi();
		qtab_t t;
		longint unsigned b;
		for (int i = 0; i < 256; i++) begin
			b = to_q(longint'(i));
			t[i] = 17'(isqrt(b << 16) - b);
		end
		return t;
	endfunction

	localparam qtab_t TOQ_TAB = build_toq();
	localparam qtab_t SL_LO_TAB = build_sl_lo();
	localparam qtab_t SL_HI_TAB = build_sl_hi();

endpackage

// ===== hdl/lbm_chan.sv =====
// One color channel of the blend pipeline: operands, divider, formula, opacity mix.
module lbm_chan import lbm_pkg::*; (
	input  logic                  clk,
	input  logic [LBM_STAGES:1]   en,
	input  lbm_cfg_t              cfg,
	input  logic [7:0]            up,
	input  logic [7:0]            down,
	input  logic                  pick,
	output logic [7:0]            mix
);

	localparam logic signed [19:0] ONE_S = 20'sd65536;

	logic [7:0]  u_s1;
	logic [7:0]  d_s1;
	logic        pick_s1;
	op_t         op_c;
	op_t         op_s2;
	dv_t         dv_s [0:DIV_STEPS-1];
	dv_t         ls;
	logic [16:0] a2, b2, na2, nb2;
	logic        u_lo2, d_lo2;

	logic [16:0] a20, b20, qcl, r_c;
	logic [18:0] pr;
	logic signed [19:0] sa, sb, sp, sq, rr;
	logic signed [9:0] pin_lo;
	logic [16:0] r_s20;
	logic [7:0]  u_s20, d_s20;
	logic        pick_s20;

	logic        blend, dissolve;
	logic [16:0] x1, x2;
	logic [23:0] pa_s21, pb_s21;
	logic [7:0]  pass_s21;
	logic [24:0] sum_s22;
	logic [7:0]  pass_s22;
	logic [25:0] vb;
	logic [16:0] xn;
	logic [32:0] pn;
	logic [7:0]  mix_c;
	logic [7:0]  mix_s23;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			u_s1 <= up;
			d_s1 <= down;
			pick_s1 <= pick;
		end
	end

	// operand select
	always_comb begin
		a2 = TOQ_TAB[u_s1];
		b2 = TOQ_TAB[d_s1];
		na2 = ONE_Q - a2;
		nb2 = ONE_Q - b2;
		u_lo2 = u_s1 <= HALF_BYTE;
		d_lo2 = d_s1 <= HALF_BYTE;
		op_c = '0;
		op_c.u = u_s1;
		op_c.d = d_s1;
		op_c.pick = pick_s1;
		case (cfg.mode)
			M_MULTIPLY: begin
				op_c.mx = {1'b0, a2};
				op_c.my = b2;
			end
			M_SCREEN: begin
				op_c.mx = {1'b0, na2};
				op_c.my = nb2;
			end
			M_OVERLAY, M_HARD_LIGHT: begin
				if ((cfg.mode == M_OVERLAY) ? d_lo2 : u_lo2) begin
					op_c.mx = {a2, 1'b0};
					op_c.my = b2;
				end else begin
					op_c.mx = {na2, 1'b0};
					op_c.my = nb2;
				end
			end
			M_SOFT_LIGHT: begin
				op_c.neg = u_lo2;
				if (u_lo2) begin
					op_c.mx = {1'b0, ONE_Q} - {a2, 1'b0};
					op_c.my = SL_LO_TAB[d_s1];
				end else begin
					op_c.mx = {a2, 1'b0} - {1'b0, ONE_Q};
					op_c.my = SL_HI_TAB[d_s1];
				end
			end
			M_EXCLUSION: begin
				op_c.mx = {a2, 1'b0};
				op_c.my = b2;
			end
			M_COLOR_BURN: begin
				op_c.num = nb2;
				op_c.dvs = a2;
			end
			M_COLOR_DODGE: begin
				op_c.num = b2;
				op_c.dvs = na2;
			end
			M_VIVID_LIGHT: begin
				if (u_lo2) begin
					op_c.num = nb2;
					op_c.dvs = {a2[15:0], 1'b0};
				end else begin
					op_c.num = b2;
					op_c.dvs = {na2[15:0], 1'b0};
				end
			end
			M_DIVIDE: begin
				op_c.num = b2;
				op_c.dvs = a2;
			end
			default: begin
			end
		endcase
		// quotient would not fit 17 bits (zero divisor included)
		op_c.ov = {1'b0, op_c.num} >= {op_c.dvs, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en[2])
			op_s2 <= op_c;
	end

	// restoring divider, one quotient bit per stage; product formed in the first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int BIT = DIV_STEPS - 1 - k;
		dv_t         src;
		dv_t         nxt;
		logic [32:0] trial;

		if (k == 0) begin : g_first
			always_comb begin
				src.u = op_s2.u;
				src.d = op_s2.d;
				src.pick = op_s2.pick;
				src.prod = 35'(op_s2.mx) * 35'(op_s2.my);
				src.neg = op_s2.neg;
				src.rem = {op_s2.num, 16'd0};
				src.dvs = op_s2.dvs;
				src.quo = '0;
				src.ov = op_s2.ov;
			end
		end else begin : g_next
			assign src = dv_s[k-1];
		end

		assign trial = 33'(src.dvs) << BIT;

		always_comb begin
			nxt = src;
			if (src.rem >= trial) begin
				nxt.rem = src.rem - trial;
				nxt.quo[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en[3+k])
				dv_s[k] <= nxt;
		end
	end

	assign ls = dv_s[DIV_STEPS-1];

	// per-mode formula and clamp to 0..1
	always_comb begin
		a20 = TOQ_TAB[ls.u];
		b20 = TOQ_TAB[ls.d];
		pr = 19'((ls.prod + 35'd32768) >> 16);
		qcl = (ls.ov || ls.quo > ONE_Q) ? ONE_Q : ls.quo;
		sa = $signed({3'b000, a20});
		sb = $signed({3'b000, b20});
		sp = $signed({1'b0, pr});
		sq = $signed({3'b000, qcl});
		pin_lo = $signed({1'b0, ls.u, 1'b0}) - 10'sd255;
		case (cfg.mode)
			M_DARKEN:       rr = (ls.u < ls.d) ? sa : sb;
			M_MULTIPLY:     rr = sp;
			M_COLOR_BURN:   rr = (ls.u == 8'd0) ? 20'sd0 : ONE_S - sq;
			M_LINEAR_BURN:  rr = sa + sb - ONE_S;
			M_LIGHTEN:      rr = (ls.u > ls.d) ? sa : sb;
			M_SCREEN:       rr = ONE_S - sp;
			M_COLOR_DODGE:  rr = (ls.u == OPAQUE) ? ONE_S : sq;
			M_LINEAR_DODGE: rr = sa + sb;
			M_OVERLAY:      rr = (ls.d <= HALF_BYTE) ? sp : ONE_S - sp;
			M_SOFT_LIGHT:   rr = (ls.neg ? -sp : sp) + sb;
			M_HARD_LIGHT:   rr = (ls.u <= HALF_BYTE) ? sp : ONE_S - sp;
			M_VIVID_LIGHT: begin
				if (ls.u == 8'd0 || ls.u == OPAQUE)
					rr = sa;
				else if (ls.u <= HALF_BYTE)
					rr = ONE_S - sq;
				else
					rr = sq;
			end
			M_LINEAR_LIGHT: rr = sb + (sa <<< 1) - ONE_S;
			M_PIN_LIGHT: begin
				if ($signed({2'b00, ls.d}) <= pin_lo)
					rr = (sa <<< 1) - ONE_S;
				else if ({1'b0, ls.d} <= {ls.u, 1'b0})
					rr = sb;
				else
					rr = sa <<< 1;
			end
			M_HARD_MIX:     rr = (9'(ls.u) + 9'(ls.d) < 9'd255) ? 20'sd0 : ONE_S;
			M_DIFFERENCE:   rr = (sa > sb) ? sa - sb : sb - sa;
			M_EXCLUSION:    rr = sa + sb - sp;
			M_SUBTRACT:     rr = sb - sa;
			M_DIVIDE:       rr = (ls.u == 8'd0) ? ONE_S : sq;
			default:        rr = 20'sd0;
		endcase
		if (rr < 20'sd0)
			r_c = '0;
		else if (rr > ONE_S)
			r_c = ONE_Q;
		else
			r_c = rr[16:0];
	end

	always_ff @(posedge clk) begin
		if (en[20]) begin
			r_s20 <= r_c;
			u_s20 <= ls.u;
			d_s20 <= ls.d;
			pick_s20 <= ls.pick;
		end
	end

	// opacity weights
	always_comb begin
		blend = cfg.mode inside {[M_DARKEN:M_DIVIDE]};
		dissolve = cfg.mode == M_DISSOLVE;
		x1 = blend ? r_s20 : {9'd0, u_s20};
		x2 = blend ? TOQ_TAB[d_s20] : {9'd0, d_s20};
	end

	always_ff @(posedge clk) begin
		if (en[21]) begin
			pa_s21 <= 24'(cfg.opacity) * 24'(x1);
			pb_s21 <= 24'(OPAQUE - cfg.opacity) * 24'(x2);
			pass_s21 <= pick_s20 ? d_s20 : u_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (en[22]) begin
			sum_s22 <= 25'(pa_s21) + 25'(pb_s21);
			pass_s22 <= pass_s21;
		end
	end

	// round and saturate; plain mode divides by 255 through a reciprocal
	always_comb begin
		vb = 26'(sum_s22) + 26'd32768;
		xn = 17'(sum_s22 + 25'd127);
		pn = 33'(xn) * 33'(RECIP_255);
		if (dissolve)
			mix_c = pass_s22;
		else if (blend)
			mix_c = (vb[25:16] > 10'(OPAQUE)) ? OPAQUE : vb[23:16];
		else
			mix_c = pn[RECIP_SHIFT+7:RECIP_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en[23])
			mix_s23 <= mix_c;
	end

	assign mix = mix_s23;

endmodule

// ===== hdl/layer_blend_mode_pixel.sv =====
// Layer blend top level: config registers, pipeline valid chain, three channel datapaths.
// Usage:
//   Input channel in_valid/in_ready moves one word: upper BGR, lower BGR, random byte.
//   Output channel out_valid/out_ready moves one blended BGR word.
//   Config channel cfg_valid/cfg_ready (always ready) writes register cfg_index:
//   0 blend mode, 1 opacity. Write only while no word is in flight.
// Pipeline:
//   Stages from input accept to output valid: input register, operand select, a
//   17-stage restoring divider (one quotient bit per stage), the mode formula,
//   the opacity multiply, the sum and the final round.
//   Throughput is one word per cycle while the output is not stalled; every stage is registered.
// Reset:
//   arst_n clears all valid bits and sets mode normal, opacity 255.
// Stall:
//   Each stage holds while it is full and the next one holds, so a stalled
//   output keeps its word and bubbles still close up; in_ready drops only when
//   the whole pipeline is full.
module layer_blend_mode_pixel import lbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] up_blue,
	input  logic [7:0] up_green,
	input  logic [7:0] up_red,
	input  logic [7:0] down_blue,
	input  logic [7:0] down_green,
	input  logic [7:0] down_red,
	input  logic [7:0] dissolve_rand,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] mix_blue,
	output logic [7:0] mix_green,
	output logic [7:0] mix_red
);

	logic [4:0]            mode_q;
	logic [7:0]            opacity_q;
	lbm_cfg_t              cfg;
	logic [LBM_STAGES:1]   vld_s;
	logic [LBM_STAGES:1]   vld_in;
	logic [LBM_STAGES:1]   en;
	logic                  pick;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			opacity_q <= OPAQUE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:    mode_q <= cfg_data[4:0];
				REG_OPACITY: opacity_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.opacity = opacity_q;

	assign en[LBM_STAGES] = !vld_s[LBM_STAGES] || out_ready;
	for (genvar k = 1; k < LBM_STAGES; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign vld_in = {vld_s[LBM_STAGES-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= (vld_s & ~en) | (vld_in & en);
	end

	assign in_ready = en[1];
	assign out_valid = vld_s[LBM_STAGES];
	assign pick = dissolve_rand >= opacity_q;

	lbm_chan u_blue (
		.clk  (clk),
		.en   (en),
		.cfg  (cfg),
		.up   (up_blue),
		.down (down_blue),
		.pick (pick),
		.mix  (mix_blue)
	);

	lbm_chan u_green (
		.clk  (clk),
		.en   (en),
		.cfg  (cfg),
		.up   (up_green),
		.down (down_green),
		.pick (pick),
		.mix  (mix_green)
	);

	lbm_chan u_red (
		.clk  (clk),
		.en   (en),
		.cfg  (cfg),
		.up   (up_red),
		.down (down_red),
		.pick (pick),
		.mix  (mix_red)
	);

endmodule

// ===== hdl/lbm_chk.sv =====
// Port-level checker for the layer blend block, bound to the top level.
`include "layer_blend_mode_pixel_defines.svh"

module lbm_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] mix_blue,
	input logic [7:0] mix_green,
	input logic [7:0] mix_red
);

	`LBM_ASSERT_RST(a_empty_out_ready, clk, arst_n, !out_valid |-> in_ready, "input blocked with empty output")
	`LBM_ASSERT_RST(a_block_cause, clk, arst_n, !in_ready |-> (out_valid && !out_ready), "input blocked without output stall")
	`LBM_ASSERT_RST(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(mix_blue) && $stable(mix_green) && $stable(mix_red)), "stalled output word changed")
	`LBM_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind layer_blend_mode_pixel lbm_chk u_lbm_chk (.*);
